>>> hw/rtl/tdu_pkg.sv
package tdu_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [3:0] FRAME_BITS = 4'd10;
	localparam logic [3:0] DATA_BITS = 4'd8;

	localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd1666;
	localparam logic [PERIOD_W-1:0] HALF_BIT_PERIOD_RST = 16'd833;

	typedef enum logic {
		REG_BIT_PERIOD = 1'b0,
		REG_HALF_BIT_PERIOD = 1'b1
	} tdu_reg_t;

	typedef struct packed {
		logic send_request;
		logic [DATA_W-1:0] send_data;
		logic line_in;
	} tdu_tick_t;

	typedef struct packed {
		logic line_out;
		logic send_busy;
	} tdu_tx_out_t;

	typedef struct packed {
		logic received_valid;
		logic [DATA_W-1:0] received_data;
	} tdu_rx_out_t;

endpackage

>>> hw/rtl/tdu_tick_if.sv
interface tdu_tick_if;
	logic valid;
	logic ready;
	logic send_request;
	logic [tdu_pkg::DATA_W-1:0] send_data;
	logic line_in;

	modport source (output valid, output send_request, output send_data, output line_in,
		input ready);
	modport sink (input valid, input send_request, input send_data, input line_in,
		output ready);
endinterface

>>> hw/rtl/tdu_result_if.sv
interface tdu_result_if;
	logic valid;
	logic ready;
	logic line_out;
	logic send_busy;
	logic received_valid;
	logic [tdu_pkg::DATA_W-1:0] received_data;

	modport source (output valid, output line_out, output send_busy, output received_valid,
		output received_data, input ready);
	modport sink (input valid, input line_out, input send_busy, input received_valid,
		input received_data, output ready);
endinterface

>>> hw/rtl/timer_driven_uart_8n1_core.sv
// channel   dir   handshake     payload
// tick      in    valid/ready   send_request, send_data[7:0], line_in
// res       out   valid/ready   line_out, send_busy, received_valid, received_data[7:0]
// apb       in    psel/penable  paddr[2:0], pwdata[31:0] -> prdata[31:0], pready high
//
// one tick per clock unless the queue is full: a two-entry queue feeds the transmit
// and receive engines, which step once per tick into a single result register
// a tick passes through a queue entry, then the result register; stalls can intervene
// arst_n clears queue, engines and result valid; periods return to 1666 and 833
// a stalled result stops the engines; the queue keeps taking ticks until full
module timer_driven_uart_8n1_core #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tdu_tick_if.sink                            tick,
	tdu_result_if.source                        res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tdu_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [tdu_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tdu_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	logic [tdu_pkg::PERIOD_W-1:0] bit_period_q;
	logic [tdu_pkg::PERIOD_W-1:0] half_bit_period_q;
	tdu_pkg::tdu_reg_t reg_sel;

	tdu_pkg::tdu_tick_t tick_req;
	tdu_pkg::tdu_tick_t head;
	logic fifo_full;
	logic fifo_not_empty;
	logic advance;

	tdu_pkg::tdu_tx_out_t tx_nxt;
	tdu_pkg::tdu_rx_out_t rx_nxt;
	tdu_pkg::tdu_tx_out_t tx_q;
	tdu_pkg::tdu_rx_out_t rx_q;
	logic res_valid_q;

	// register access
	assign pready = 1'b1;
	assign reg_sel = tdu_pkg::tdu_reg_t'(paddr[2]);

	always_comb begin
		case (reg_sel)
			tdu_pkg::REG_BIT_PERIOD: prdata = {16'd0, bit_period_q};
			tdu_pkg::REG_HALF_BIT_PERIOD: prdata = {16'd0, half_bit_period_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= tdu_pkg::BIT_PERIOD_RST;
			half_bit_period_q <= tdu_pkg::HALF_BIT_PERIOD_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				tdu_pkg::REG_BIT_PERIOD: bit_period_q <= pwdata[tdu_pkg::PERIOD_W-1:0];
				tdu_pkg::REG_HALF_BIT_PERIOD:
					half_bit_period_q <= pwdata[tdu_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// front: tick queue
	assign tick_req.send_request = tick.send_request;
	assign tick_req.send_data = tick.send_data;
	assign tick_req.line_in = tick.line_in;
	assign tick.ready = !fifo_full;

	tdu_tick_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tick.valid),
		.push_data (tick_req),
		.full      (fifo_full),
		.pop       (advance),
		.not_empty (fifo_not_empty),
		.pop_data  (head)
	);

	// back: engines step when the queue holds a tick and the result slot is free or draining
	assign advance = fifo_not_empty && (!res_valid_q || res.ready);

	tdu_tx #(.TIMER_WIDTH(TIMER_WIDTH)) u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.req        (head.send_request),
		.data       (head.send_data),
		.bit_period (bit_period_q),
		.status_nxt (tx_nxt)
	);

	tdu_rx #(.TIMER_WIDTH(TIMER_WIDTH)) u_rx (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.line_in         (head.line_in),
		.bit_period      (bit_period_q),
		.half_bit_period (half_bit_period_q),
		.status_nxt      (rx_nxt)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_q <= tx_nxt;
			rx_q <= rx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid = res_valid_q;
	assign res.line_out = tx_q.line_out;
	assign res.send_busy = tx_q.send_busy;
	assign res.received_valid = rx_q.received_valid;
	assign res.received_data = rx_q.received_data;

endmodule

>>> hw/rtl/tdu_tick_fifo.sv
module tdu_tick_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tdu_pkg::tdu_tick_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output tdu_pkg::tdu_tick_t pop_data
);

	tdu_pkg::tdu_tick_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
		end
	end

endmodule

>>> hw/rtl/tdu_tx.sv
module tdu_tx #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           req,
	input  logic [tdu_pkg::DATA_W-1:0]     data,
	input  logic [tdu_pkg::PERIOD_W-1:0]   bit_period,
	output tdu_pkg::tdu_tx_out_t           status_nxt
);

	logic [9:0] shift_q, shift_d;
	logic [3:0] bits_left_q, bits_left_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic active_q, active_d;
	logic line_q, line_d;
	logic [31:0] period_ext;
	logic [TIMER_WIDTH-1:0] reload;

	assign period_ext = {16'd0, bit_period};
	assign reload = period_ext[TIMER_WIDTH-1:0];

	always_comb begin
		shift_d = shift_q;
		bits_left_d = bits_left_q;
		timer_d = timer_q;
		active_d = active_q;
		line_d = line_q;
		if (!active_q) begin
			if (req) begin
				shift_d = {1'b1, data, 1'b0};
				bits_left_d = tdu_pkg::FRAME_BITS;
				timer_d = reload;
				active_d = 1'b1;
			end
		end else if (timer_q <= TIMER_WIDTH'(1)) begin
			timer_d = reload;
			if (bits_left_q == 4'd0) begin
				line_d = 1'b1;
				active_d = 1'b0;
				bits_left_d = tdu_pkg::FRAME_BITS;
			end else begin
				if (bits_left_q >= tdu_pkg::FRAME_BITS) begin
					line_d = 1'b1;
				end else begin
					line_d = shift_q[0];
					shift_d = {1'b0, shift_q[9:1]};
				end
				bits_left_d = bits_left_q - 4'd1;
			end
		end else begin
			timer_d = timer_q - TIMER_WIDTH'(1);
		end
	end

	assign status_nxt.line_out = line_d;
	assign status_nxt.send_busy = active_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bits_left_q <= tdu_pkg::FRAME_BITS;
			timer_q <= '0;
			active_q <= 1'b0;
			line_q <= 1'b1;
		end else if (en) begin
			shift_q <= shift_d;
			bits_left_q <= bits_left_d;
			timer_q <= timer_d;
			active_q <= active_d;
			line_q <= line_d;
		end
	end

endmodule

>>> hw/rtl/tdu_rx.sv
module tdu_rx #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           line_in,
	input  logic [tdu_pkg::PERIOD_W-1:0]   bit_period,
	input  logic [tdu_pkg::PERIOD_W-1:0]   half_bit_period,
	output tdu_pkg::tdu_rx_out_t           status_nxt
);

	logic hunting_q, hunting_d;
	logic [7:0] shift_q, shift_d;
	logic [3:0] bits_left_q, bits_left_d;
	logic [TIMER_WIDTH:0] timer_q, timer_d;
	logic prev_q;
	logic [7:0] holding_q, holding_d;
	logic done;
	logic [32:0] period_ext;
	logic [32:0] first_ext;

	assign period_ext = {17'd0, bit_period};
	assign first_ext = {17'd0, bit_period} + {17'd0, half_bit_period};

	always_comb begin
		hunting_d = hunting_q;
		shift_d = shift_q;
		bits_left_d = bits_left_q;
		timer_d = timer_q;
		holding_d = holding_q;
		done = 1'b0;
		if (hunting_q) begin
			if (prev_q && !line_in) begin
				hunting_d = 1'b0;
				bits_left_d = tdu_pkg::DATA_BITS;
				timer_d = first_ext[TIMER_WIDTH:0];
			end
		end else if (timer_q <= (TIMER_WIDTH+1)'(1)) begin
			shift_d = {line_in, shift_q[7:1]};
			if (bits_left_q <= 4'd1) begin
				holding_d = shift_d;
				bits_left_d = tdu_pkg::DATA_BITS;
				hunting_d = 1'b1;
				done = 1'b1;
			end else begin
				bits_left_d = bits_left_q - 4'd1;
				timer_d = period_ext[TIMER_WIDTH:0];
			end
		end else begin
			timer_d = timer_q - (TIMER_WIDTH+1)'(1);
		end
	end

	assign status_nxt.received_valid = done;
	assign status_nxt.received_data = holding_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			shift_q <= '0;
			bits_left_q <= tdu_pkg::DATA_BITS;
			timer_q <= '0;
			prev_q <= 1'b1;
			holding_q <= '0;
		end else if (en) begin
			hunting_q <= hunting_d;
			shift_q <= shift_d;
			bits_left_q <= bits_left_d;
			timer_q <= timer_d;
			prev_q <= line_in;
			holding_q <= holding_d;
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		tdu_pkg::tdu_tx_out_t tx;
		tdu_pkg::tdu_rx_out_t rx;
	} uart_outputs_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tdu_pkg::APB_ADDR_W-1:0] paddr;
	logic [tdu_pkg::APB_DATA_W-1:0] pwdata;
	logic [tdu_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	tdu_tick_if tick_ch ();
	tdu_result_if res_ch ();

	timer_driven_uart_8n1_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// uart model state
	logic [tdu_pkg::PERIOD_W-1:0] cfg_bit;
	logic [tdu_pkg::PERIOD_W-1:0] cfg_half;
	logic [9:0] tx_shift;
	logic [3:0] tx_left;
	logic [15:0] tx_timer;
	logic tx_active;
	logic tx_line;
	logic rx_hunt;
	logic [7:0] rx_shift;
	logic [3:0] rx_left;
	logic [16:0] rx_timer;
	logic rx_prev;
	logic [7:0] rx_hold;

	tdu_pkg::tdu_tick_t pending_ticks[$];
	uart_outputs_t predicted_outputs[$];
	bit line_plan[$];

	int send_gap;
	int recv_stall;
	int long_hold;
	bit tick_took;
	bit send_idle_on;
	bit recv_idle_on;
	bit hold_req;
	bit hold_done;
	int mismatches = 0;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic reset_model();
		cfg_bit = tdu_pkg::BIT_PERIOD_RST;
		cfg_half = tdu_pkg::HALF_BIT_PERIOD_RST;
		tx_shift = '0;
		tx_left = tdu_pkg::FRAME_BITS;
		tx_timer = '0;
		tx_active = 1'b0;
		tx_line = 1'b1;
		rx_hunt = 1'b1;
		rx_shift = '0;
		rx_left = tdu_pkg::DATA_BITS;
		rx_timer = '0;
		rx_prev = 1'b1;
		rx_hold = '0;
	endtask

	function automatic uart_outputs_t advance_uart(tdu_pkg::tdu_tick_t t);
		uart_outputs_t o;
		logic done;
		done = 1'b0;
		if (!tx_active) begin
			if (t.send_request) begin
				tx_shift = {1'b1, t.send_data, 1'b0};
				tx_left = tdu_pkg::FRAME_BITS;
				tx_timer = cfg_bit;
				tx_active = 1'b1;
			end
		end else if (tx_timer <= 1) begin
			tx_timer = cfg_bit;
			if (tx_left == 0) begin
				tx_line = 1'b1;
				tx_active = 1'b0;
				tx_left = tdu_pkg::FRAME_BITS;
			end else begin
				if (tx_left >= tdu_pkg::FRAME_BITS) begin
					tx_line = 1'b1;
				end else begin
					tx_line = tx_shift[0];
					tx_shift = tx_shift >> 1;
				end
				tx_left = tx_left - 1'b1;
			end
		end else begin
			tx_timer = tx_timer - 1'b1;
		end

		if (rx_hunt) begin
			if (rx_prev && !t.line_in) begin
				rx_hunt = 1'b0;
				rx_left = tdu_pkg::DATA_BITS;
				rx_timer = {1'b0, cfg_bit} + {1'b0, cfg_half};
			end
		end else if (rx_timer <= 1) begin
			rx_shift = {t.line_in, rx_shift[7:1]};
			if (rx_left <= 1) begin
				rx_hold = rx_shift;
				rx_left = tdu_pkg::DATA_BITS;
				rx_hunt = 1'b1;
				done = 1'b1;
			end else begin
				rx_left = rx_left - 1'b1;
				rx_timer = {1'b0, cfg_bit};
			end
		end else begin
			rx_timer = rx_timer - 1'b1;
		end
		rx_prev = t.line_in;

		o.tx.line_out = tx_line;
		o.tx.send_busy = tx_active;
		o.rx.received_valid = done;
		o.rx.received_data = rx_hold;
		return o;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timer_driven_uart_8n1_core: mismatch");
			$finish;
		end
	end

	// accept requests into the model, check results in order
	always @(posedge clk) begin : monitor
		uart_outputs_t want;
		tdu_pkg::tdu_tick_t taken;
		tick_took = 1'b0;
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				tick_took = 1'b1;
				taken = {tick_ch.send_request, tick_ch.send_data, tick_ch.line_in};
				predicted_outputs.push_back(advance_uart(taken));
			end
			if (res_ch.valid && res_ch.ready) begin
				if (predicted_outputs.size() == 0) begin
					flag_mismatch("result with none pending", 32'h0, 32'h1);
				end else begin
					want = predicted_outputs.pop_front();
					if (res_ch.line_out !== want.tx.line_out)
						flag_mismatch("line_out", want.tx.line_out, res_ch.line_out);
					if (res_ch.send_busy !== want.tx.send_busy)
						flag_mismatch("send_busy", want.tx.send_busy, res_ch.send_busy);
					if (res_ch.received_valid !== want.rx.received_valid)
						flag_mismatch("received_valid", want.rx.received_valid,
							res_ch.received_valid);
					if (res_ch.received_data !== want.rx.received_data)
						flag_mismatch("received_data", want.rx.received_data,
							res_ch.received_data);
				end
			end
		end
	end

	always @(negedge clk) begin : driver
		tdu_pkg::tdu_tick_t next_tick;
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
		end else if (!tick_ch.valid || tick_took) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				tick_ch.valid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				next_tick = pending_ticks.pop_front();
				tick_ch.send_request <= next_tick.send_request;
				tick_ch.send_data <= next_tick.send_data;
				tick_ch.line_in <= next_tick.line_in;
				tick_ch.valid <= 1'b1;
				send_gap <= send_idle_on ? idle_gap() : 0;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			long_hold <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (long_hold > 0) begin
			long_hold <= long_hold - 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (long_hold > 0) begin
			res_ch.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			recv_stall <= recv_idle_on ? idle_gap() : 0;
		end
	end

	task automatic apb_write(tdu_pkg::tdu_reg_t r, logic [tdu_pkg::PERIOD_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tdu_pkg::APB_ADDR_W'(4 * int'(r));
		pwdata <= tdu_pkg::APB_DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (r == tdu_pkg::REG_BIT_PERIOD)
			cfg_bit = v;
		else
			cfg_half = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_check(tdu_pkg::tdu_reg_t r, logic [tdu_pkg::PERIOD_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= tdu_pkg::APB_ADDR_W'(4 * int'(r));
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== tdu_pkg::APB_DATA_W'(v))
			flag_mismatch("register readback", tdu_pkg::APB_DATA_W'(v), prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_periods(logic [tdu_pkg::PERIOD_W-1:0] bp,
		logic [tdu_pkg::PERIOD_W-1:0] hp);
		apb_write(tdu_pkg::REG_BIT_PERIOD, bp);
		apb_write(tdu_pkg::REG_HALF_BIT_PERIOD, hp);
		apb_check(tdu_pkg::REG_BIT_PERIOD, bp);
		apb_check(tdu_pkg::REG_HALF_BIT_PERIOD, hp);
	endtask

	task automatic push_tick(bit req, logic [7:0] data);
		tdu_pkg::tdu_tick_t t;
		t.send_request = req;
		t.send_data = data;
		t.line_in = (line_plan.size() != 0) ? line_plan.pop_front() : 1'b1;
		pending_ticks.push_back(t);
	endtask

	// idle, start, eight data bits lsb first, stop
	task automatic plan_frame(logic [7:0] b, int bit_ticks, int idle);
		repeat (idle) line_plan.push_back(1'b1);
		repeat (bit_ticks) line_plan.push_back(1'b0);
		for (int i = 0; i < 8; i++)
			repeat (bit_ticks) line_plan.push_back(b[i]);
		repeat (bit_ticks) line_plan.push_back(1'b1);
	endtask

	task automatic plan_noise();
		int n;
		n = $urandom_range(1, 12);
		repeat (n) line_plan.push_back(1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || tick_ch.valid || predicted_outputs.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(logic [tdu_pkg::PERIOD_W-1:0] bp,
		logic [tdu_pkg::PERIOD_W-1:0] hp, int count, bit with_hold);
		int bit_ticks;
		int r;
		set_periods(bp, hp);
		bit_ticks = (bp == 0) ? 1 : int'(bp);
		@(posedge clk);
		send_idle_on = ($urandom_range(0, 3) != 0);
		recv_idle_on = ($urandom_range(0, 3) != 0);
		if (with_hold)
			hold_req = 1'b1;
		repeat (count) begin
			if (line_plan.size() == 0) begin
				r = $urandom_range(0, 9);
				if (bit_ticks > 64 || r >= 8)
					plan_noise();
				else if (r < 7)
					plan_frame(8'($urandom), bit_ticks, $urandom_range(1, 4));
				else
					plan_frame($urandom_range(0, 1) ? 8'hFF : 8'h00, bit_ticks, 1);
			end
			r = $urandom_range(0, 99);
			push_tick(r < 12, (r < 3) ? 8'hFF : (r < 6) ? 8'h00 : 8'($urandom));
		end
		drain();
		line_plan.delete();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.send_request = 1'b0;
		tick_ch.send_data = '0;
		tick_ch.line_in = 1'b1;
		res_ch.ready = 1'b0;
		send_gap = 0;
		recv_stall = 0;
		long_hold = 0;
		tick_took = 1'b0;
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_check(tdu_pkg::REG_BIT_PERIOD, tdu_pkg::BIT_PERIOD_RST);
		apb_check(tdu_pkg::REG_HALF_BIT_PERIOD, tdu_pkg::HALF_BIT_PERIOD_RST);
		@(posedge clk);
		repeat (6) push_tick(1'b0, 8'($urandom));
		drain();

		// zero periods behave as one tick
		set_periods(16'd0, 16'd0);
		@(posedge clk);
		plan_frame(8'h00, 1, 1);
		plan_frame(8'hFF, 1, 1);
		for (int i = 0; i < 24; i++) begin
			case (i)
				0: push_tick(1'b1, 8'h00);
				4: push_tick(1'b1, 8'hFF);
				12: push_tick(1'b1, 8'hFF);
				14: push_tick(1'b1, 8'h55);
				default: push_tick(1'b0, 8'($urandom));
			endcase
		end
		drain();
		line_plan.delete();

		run_phase(16'd2, 16'd1, 170, 1'b0);
		run_phase(16'd3, 16'd1, 170, 1'b0);
		run_phase(16'd4, 16'd2, 170, 1'b1);
		run_phase(16'd5, 16'd3, 170, 1'b0);
		run_phase(16'd2, 16'd2, 100, 1'b0);
		run_phase(16'd7, 16'($urandom_range(1, 6)), 170, 1'b0);
		run_phase(16'd1666, 16'd833, 40, 1'b0);
		run_phase(16'd65535, 16'd65535, 40, 1'b0);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && predicted_outputs.size() == 0) begin
			$display("timer_driven_uart_8n1_core: match");
		end else begin
			$display("timer_driven_uart_8n1_core: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/tdu_pkg.sv
hw/rtl/tdu_tick_if.sv
hw/rtl/tdu_result_if.sv
hw/rtl/tdu_tick_fifo.sv
hw/rtl/tdu_tx.sv
hw/rtl/tdu_rx.sv
hw/rtl/timer_driven_uart_8n1_core.sv
sim/tb.sv
